### hdl/quaternion_to_euler_defines.svh
// assertion macros for the quaternion to euler angle block
`ifndef QUATERNION_TO_EULER_DEFINES_SVH
`define QUATERNION_TO_EULER_DEFINES_SVH
`ifndef SYNTHESIS
`define Q2E_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");
`define Q2E_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define Q2E_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define Q2E_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

### hdl/q2e_pkg.sv
// shared types, constants and helper functions for the quaternion to euler block
package q2e_pkg;

  localparam int QW       = 16;
  localparam int AF       = 13;
  localparam int WF       = 30;
  localparam int CS       = 16;
  localparam int SW       = 35;
  localparam int CW       = 38;
  localparam int SQ_STEPS = 31;
  localparam int RSH      = WF - AF;

  localparam logic signed [SW-1:0] ONE_Q30     = 35'sd1073741824;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 38'sd1686629713;
  localparam logic signed [15:0]   PI_OUT      = 16'sd25736;
  localparam logic signed [15:0]   HALF_OUT    = 16'sd12868;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [SW-1:0] sr;
    logic signed [SW-1:0] cr;
    logic signed [SW-1:0] sy;
    logic signed [SW-1:0] cy;
    logic signed [SW-1:0] sp;
    logic                 clamped;
  } aux_t;

  typedef struct packed {
    logic [61:0] n;
    logic [32:0] r;
    logic [30:0] q;
  } sqrt_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 zero;
  } chan_t;

  function automatic chan_t prerot(logic signed [CW-1:0] y, logic signed [CW-1:0] x);
    chan_t c;
    c.zero = (x == '0) && (y == '0);
    c.x = x;
    c.y = y;
    c.z = '0;
    if (x[CW-1]) begin
      if (!y[CW-1]) begin
        c.z = HALF_PI_Q30;
        c.x = y;
        c.y = -x;
      end else begin
        c.z = -HALF_PI_Q30;
        c.x = -y;
        c.y = x;
      end
    end
    return c;
  endfunction

  function automatic logic signed [15:0] to_out(logic signed [CW-1:0] z,
                                                logic signed [15:0] bound);
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] b;
    logic signed [15:0]   v;
    s = (z + (CW'(1) <<< (RSH - 1))) >>> RSH;
    b = CW'(bound);
    if (s > b) v = bound;
    else if (s < -b) v = -bound;
    else v = s[15:0];
    return v;
  endfunction

endpackage

### hdl/q2e_front.sv
// products, sums, clamp test and sine square feeding the square root chain
module q2e_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [q2e_pkg::QW-1:0] x,
  input  logic signed [q2e_pkg::QW-1:0] y,
  input  logic signed [q2e_pkg::QW-1:0] z,
  input  logic signed [q2e_pkg::QW-1:0] w,
  output logic                        out_valid,
  output q2e_pkg::sqrt_t              s_out,
  output q2e_pkg::aux_t               a_out
);

  logic signed [31:0] p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic               v1, v2;
  q2e_pkg::aux_t      a2;
  logic signed [q2e_pkg::SW-1:0] sp2;
  logic signed [30:0] sp30;
  logic signed [61:0] sq;

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= w * x;
      p_yz <= y * z;
      p_xx <= x * x;
      p_yy <= y * y;
      p_wy <= w * y;
      p_zx <= z * x;
      p_wz <= w * z;
      p_xy <= x * y;
      p_zz <= z * z;
    end
  end

  assign sp2 = (q2e_pkg::SW'(p_wy) - q2e_pkg::SW'(p_zx)) <<< 1;

  always_ff @(posedge clk) begin
    if (en) begin
      a2.sr <= (q2e_pkg::SW'(p_wx) + q2e_pkg::SW'(p_yz)) <<< 1;
      a2.cr <= q2e_pkg::ONE_Q30 - ((q2e_pkg::SW'(p_xx) + q2e_pkg::SW'(p_yy)) <<< 1);
      a2.sy <= (q2e_pkg::SW'(p_wz) + q2e_pkg::SW'(p_xy)) <<< 1;
      a2.cy <= q2e_pkg::ONE_Q30 - ((q2e_pkg::SW'(p_yy) + q2e_pkg::SW'(p_zz)) <<< 1);
      a2.sp <= sp2;
      a2.clamped <= (sp2 >= q2e_pkg::ONE_Q30) || (sp2 <= -q2e_pkg::ONE_Q30);
    end
  end

  assign sp30 = a2.sp[30:0];
  assign sq   = sp30 * sp30;

  always_ff @(posedge clk) begin
    if (en) begin
      a_out         <= a2;
      s_out.n       <= (62'd1 << 60) - 62'(sq);
      s_out.r       <= '0;
      s_out.q       <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

endmodule

### hdl/q2e_sqrt_cell.sv
// one root digit of the pitch cosine square root
module q2e_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  q2e_pkg::sqrt_t s_in,
  input  q2e_pkg::aux_t  a_in,
  output q2e_pkg::sqrt_t s_out,
  output q2e_pkg::aux_t  a_out
);

  logic [34:0] rs;
  logic [34:0] t;

  assign rs = {s_in.r, s_in.n[61:60]};
  assign t  = {2'b00, s_in.q, 2'b01};

  always_ff @(posedge clk) begin
    if (en) begin
      a_out   <= a_in;
      s_out.n <= {s_in.n[59:0], 2'b00};
      if (rs >= t) begin
        s_out.r <= 33'(rs - t);
        s_out.q <= {s_in.q[29:0], 1'b1};
      end else begin
        s_out.r <= rs[32:0];
        s_out.q <= {s_in.q[29:0], 1'b0};
      end
    end
  end

endmodule

### hdl/q2e_cordic_cell.sv
// one vectoring rotation of the angle cordic
module q2e_cordic_cell (
  input  logic           clk,
  input  logic           en,
  input  logic [4:0]     shift,
  input  logic [31:0]    atan,
  input  q2e_pkg::chan_t c_in,
  output q2e_pkg::chan_t c_out
);

  logic signed [q2e_pkg::CW-1:0] xs, ys, a;

  assign xs = c_in.x >>> shift;
  assign ys = c_in.y >>> shift;
  assign a  = q2e_pkg::CW'(atan);

  always_ff @(posedge clk) begin
    if (en) begin
      c_out.zero <= c_in.zero;
      if (!c_in.y[q2e_pkg::CW-1]) begin
        c_out.x <= c_in.x + ys;
        c_out.y <= c_in.y - xs;
        c_out.z <= c_in.z + a;
      end else begin
        c_out.x <= c_in.x - ys;
        c_out.y <= c_in.y + xs;
        c_out.z <= c_in.z - a;
      end
    end
  end

endmodule

### hdl/quaternion_to_euler.sv
// quaternion to roll, pitch and yaw, fully pipelined
// One quaternion request is taken every cycle while the output is free or being
// taken; each request passes through three front stages (products, sums, sine
// square), 31 square root digit cells, one quadrant stage, 16 cordic cells per
// angle and one rounding stage. A stalled output stalls the whole chain.
`include "quaternion_to_euler_defines.svh"
module quaternion_to_euler (
  input  logic               clk,
  input  logic               rst,
  input  logic               quat_valid,
  output logic               quat_stall,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic               euler_valid,
  input  logic               euler_stall,
  output logic signed [15:0] roll_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] yaw_angle,
  output logic               pitch_clamped
);

  localparam int SQ = q2e_pkg::SQ_STEPS;
  localparam int CS = q2e_pkg::CS;

  logic           en;
  q2e_pkg::sqrt_t sq_s [SQ+1];
  q2e_pkg::aux_t  sq_a [SQ+1];
  logic [SQ:0]    sv;
  q2e_pkg::chan_t ch [CS+1][3];
  logic [CS:0]    cv, cl, ng;
  q2e_pkg::aux_t  af;

  assign en         = !euler_valid || !euler_stall;
  assign quat_stall = !en;

  q2e_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(quat_valid),
    .x(quat_x), .y(quat_y), .z(quat_z), .w(quat_w),
    .out_valid(sv[0]), .s_out(sq_s[0]), .a_out(sq_a[0])
  );

  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk(clk), .en(en), .s_in(sq_s[j]), .a_in(sq_a[j]),
      .s_out(sq_s[j+1]), .a_out(sq_a[j+1])
    );
  end

  assign af = sq_a[SQ];

  always_ff @(posedge clk) begin
    if (en) begin
      ch[0][0] <= q2e_pkg::prerot(q2e_pkg::CW'(af.sr), q2e_pkg::CW'(af.cr));
      ch[0][1] <= q2e_pkg::prerot(q2e_pkg::CW'(af.sp),
                                  q2e_pkg::CW'({1'b0, sq_s[SQ].q}));
      ch[0][2] <= q2e_pkg::prerot(q2e_pkg::CW'(af.sy), q2e_pkg::CW'(af.cy));
      cl[0]    <= af.clamped;
      ng[0]    <= af.sp[q2e_pkg::SW-1];
    end
  end

  for (genvar i = 0; i < CS; i++) begin : g_stage
    for (genvar k = 0; k < 3; k++) begin : g_chan
      q2e_cordic_cell u_cell (
        .clk(clk), .en(en), .shift(5'(i)), .atan(q2e_pkg::ATAN_Q30[i]),
        .c_in(ch[i][k]), .c_out(ch[i+1][k])
      );
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cl[i+1] <= cl[i];
        ng[i+1] <= ng[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[SQ:1]    <= '0;
      cv          <= '0;
      euler_valid <= 1'b0;
    end else if (en) begin
      sv[SQ:1]    <= sv[SQ-1:0];
      cv          <= {cv[CS-1:0], sv[SQ]};
      euler_valid <= cv[CS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle    <= ch[CS][0].zero ? '0 : q2e_pkg::to_out(ch[CS][0].z, q2e_pkg::PI_OUT);
      yaw_angle     <= ch[CS][2].zero ? '0 : q2e_pkg::to_out(ch[CS][2].z, q2e_pkg::PI_OUT);
      pitch_clamped <= cl[CS];
      if (cl[CS]) begin
        pitch_angle <= ng[CS] ? 15'(-q2e_pkg::HALF_OUT) : 15'(q2e_pkg::HALF_OUT);
      end else if (ch[CS][1].zero) begin
        pitch_angle <= '0;
      end else begin
        pitch_angle <= 15'(q2e_pkg::to_out(ch[CS][1].z, q2e_pkg::HALF_OUT));
      end
    end
  end

  `Q2E_ASSERT_IMP(a_clamp_value, clk, rst, euler_valid && pitch_clamped, (pitch_angle == 15'(q2e_pkg::HALF_OUT)) || (pitch_angle == 15'(-q2e_pkg::HALF_OUT)))
  `Q2E_ASSERT_IMP(a_roll_range, clk, rst, euler_valid, (roll_angle <= q2e_pkg::PI_OUT) && (roll_angle >= -q2e_pkg::PI_OUT))
  `Q2E_ASSERT_IMP(a_yaw_range, clk, rst, euler_valid, (yaw_angle <= q2e_pkg::PI_OUT) && (yaw_angle >= -q2e_pkg::PI_OUT))
  `Q2E_ASSERT_NXT(a_chain_hold, clk, rst, !en, $stable(sv) && $stable(cv))

endmodule
